[sv/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and codes of the indexed lexicographic priority heap.
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int ELEM_LIMIT = 1024;
   localparam int ROW_ELEMS  = 16;

   typedef enum logic [2:0] {
      CMD_UPDATE = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_PEEK   = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_WRONG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      COLOR_WHITE = 2'd0,
      COLOR_GRAY  = 2'd1,
      COLOR_BLACK = 2'd2
   } color_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHK, S_RM_B, S_RM_L, S_RM_K, S_DL1, S_DL2, S_DL3,
      S_UP, S_UP1, S_UP2, S_DOWN, S_D1, S_D2, S_D3, S_D4, S_FIN, S_DONE
   } state_type;

   typedef struct packed {
      logic signed [31:0] key_first;
      logic signed [31:0] key_second;
      logic signed [31:0] key_third;
      logic signed [31:0] key_fourth;
   } key_set_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [9:0]         element;
      logic signed [31:0] key_first;
      logic signed [31:0] key_second;
      logic signed [31:0] key_third;
      logic signed [31:0] key_fourth;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  top_element;
      logic        top_valid;
      logic        is_empty;
      logic        is_full;
      logic [10:0] count;
   } rsp_type;

endpackage

[sv/lph_ram.sv]
// ----------------------------------------------------------------------------
// lph_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

[sv/lph_cmp.sv]
// ----------------------------------------------------------------------------
// lph_cmp
// Shared lexicographic comparator over four signed keys.
// ----------------------------------------------------------------------------
module lph_cmp (
   input  lph_pkg::key_set_type a,
   input  lph_pkg::key_set_type b,
   input  logic                 largest_first,
   output logic                 ahead
);
   import lph_pkg::*;

   logic lt, gt;

   always_comb begin
      lt = 1'b0;
      gt = 1'b0;
      if (a.key_first != b.key_first) begin
         lt = a.key_first < b.key_first;
      end else if (a.key_second != b.key_second) begin
         lt = a.key_second < b.key_second;
      end else if (a.key_third != b.key_third) begin
         lt = a.key_third < b.key_third;
      end else begin
         lt = a.key_fourth < b.key_fourth;
      end
      gt = !lt && (a != b);
      ahead = largest_first ? gt : lt;
   end
endmodule

[sv/indexed_lex_priority_heap.sv]
// ----------------------------------------------------------------------------
// indexed_lex_priority_heap
// Indexed binary heap of element numbers ordered on four signed keys.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the result has been shown for one cycle on rsp_payload with rsp_strobe, and
// the receiver must take it then. Peek and clear walk no heap level. An update
// climbs the heap level by level, a remove descends it and a delete may do
// either: each level climbed costs a heap slot read, a key read and one pass
// through the shared comparator, each level descended up to two of each, all
// on single-read-port memories. Clear is immediate because colours are held
// in rows of sixteen, each row with its own valid flag.
// ----------------------------------------------------------------------------
module indexed_lex_priority_heap #(
   parameter int CAPACITY = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lph_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output lph_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic             csr_wdata
);
   import lph_pkg::*;

   localparam int ELEM_DEPTH = (CAPACITY < ELEM_LIMIT) ? CAPACITY : ELEM_LIMIT;
   localparam int HEAP_DEPTH = ELEM_DEPTH + 1;
   localparam int HA_W = $clog2(HEAP_DEPTH);
   localparam int EA_W = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;
   localparam int ROWS = (ELEM_DEPTH + ROW_ELEMS - 1) / ROW_ELEMS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [16:0] CAP_L = 17'(CAPACITY);

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [10:0] occ_ff, occ_in;
   logic        largest_ff;
   logic [10:0] slot_ff, slot_in;
   logic [10:0] pick_ff, pick_in;
   logic [9:0]  e_ff, e_in;
   logic [9:0]  oel_ff, oel_in;
   logic [9:0]  rel_ff, rel_in;
   key_set_type ekey_ff, ekey_in;
   key_set_type okey_ff, okey_in;
   logic [9:0]  top_ff, top_in;
   logic        top_valid_ff, top_valid_in;
   status_type  status_ff, status_in;
   logic        row_valid_ff [ROWS];

   // Memory ports
   logic            heap_we;
   logic [HA_W-1:0] heap_waddr, heap_raddr;
   logic [9:0]      heap_wdata, heap_rdata;
   logic            pos_we;
   logic [EA_W-1:0] pos_waddr, pos_raddr;
   logic [10:0]     pos_wdata, pos_rdata;
   logic            key_we;
   logic [EA_W-1:0] key_waddr, key_raddr;
   key_set_type     key_wdata;
   logic [127:0]    key_rdata_raw;
   key_set_type     key_rdata;
   logic             col_we;
   logic [ROW_W-1:0] col_raddr;
   logic [9:0]       col_wel;
   color_type        col_wcolor;
   logic [31:0]      col_wdata, col_rdata, col_base;
   logic             clr_valid;

   key_set_type cmp_a, cmp_b;
   logic        ahead;

   key_set_type req_keys;
   color_type   color_cur;
   logic        el_ok;
   logic [11:0] left, right;
   logic [ROW_W-1:0] req_row, wr_row;

   lph_ram #(.WIDTH(10), .DEPTH(HEAP_DEPTH), .AW(HA_W)) u_heap (
      .clock(clock), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
      .raddr(heap_raddr), .rdata(heap_rdata));

   lph_ram #(.WIDTH(11), .DEPTH(ELEM_DEPTH), .AW(EA_W)) u_pos (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata));

   lph_ram #(.WIDTH(128), .DEPTH(ELEM_DEPTH), .AW(EA_W)) u_keys (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
      .raddr(key_raddr), .rdata(key_rdata_raw));

   lph_ram #(.WIDTH(32), .DEPTH(ROWS), .AW(ROW_W)) u_color (
      .clock(clock), .we(col_we), .waddr(wr_row), .wdata(col_wdata),
      .raddr(col_raddr), .rdata(col_rdata));

   lph_cmp u_cmp (.a(cmp_a), .b(cmp_b), .largest_first(largest_ff), .ahead(ahead));

   assign key_rdata = key_set_type'(key_rdata_raw);
   assign req_keys = '{key_first: req_ff.key_first, key_second: req_ff.key_second,
                       key_third: req_ff.key_third, key_fourth: req_ff.key_fourth};
   assign el_ok = {7'b0, req_ff.element} < CAP_L;
   assign req_row = ROW_W'(req_ff.element >> 4);
   assign wr_row = ROW_W'(col_wel >> 4);
   assign left = {slot_ff, 1'b0};
   assign right = left + 12'd1;

   // The colour row read back is the row that is then written, so an invalid
   // row reads as all white.
   always_comb begin
      col_base = row_valid_ff[wr_row] ? col_rdata : '0;
      col_wdata = col_base;
      col_wdata[{col_wel[3:0], 1'b0} +: 2] = col_wcolor;
      color_cur = color_type'(row_valid_ff[req_row] ?
                  col_rdata[{req_ff.element[3:0], 1'b0} +: 2] : COLOR_WHITE);
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      occ_in = occ_ff;
      slot_in = slot_ff;
      pick_in = pick_ff;
      e_in = e_ff;
      oel_in = oel_ff;
      rel_in = rel_ff;
      ekey_in = ekey_ff;
      okey_in = okey_ff;
      top_in = top_ff;
      top_valid_in = top_valid_ff;
      status_in = status_ff;
      heap_we = 1'b0;
      heap_waddr = '0;
      heap_wdata = e_ff;
      heap_raddr = '0;
      pos_we = 1'b0;
      pos_waddr = '0;
      pos_wdata = slot_ff;
      pos_raddr = '0;
      key_we = 1'b0;
      key_waddr = EA_W'(req_ff.element);
      key_wdata = req_keys;
      key_raddr = '0;
      col_we = 1'b0;
      col_wel = req_ff.element;
      col_wcolor = COLOR_WHITE;
      col_raddr = '0;
      clr_valid = 1'b0;
      cmp_a = ekey_ff;
      cmp_b = key_rdata;
      busy = 1'b1;
      rsp_strobe = 1'b0;

      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            heap_raddr = HA_W'(1);
            pos_raddr = EA_W'(req_payload.element);
            col_raddr = ROW_W'(req_payload.element >> 4);
            if (start) begin
               req_in = req_payload;
               status_in = ST_OK;
               top_in = '0;
               top_valid_in = 1'b0;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = S_DONE;
            case (req_ff.cmd)
               CMD_UPDATE: begin
                  if (!el_ok || color_cur == COLOR_BLACK) begin
                     status_in = ST_WRONG;
                  end else if (color_cur == COLOR_WHITE && {6'b0, occ_ff} >= CAP_L) begin
                     status_in = ST_FULL;
                  end else begin
                     key_we = 1'b1;
                     ekey_in = req_keys;
                     e_in = req_ff.element;
                     if (color_cur == COLOR_WHITE) begin
                        occ_in = occ_ff + 11'd1;
                        slot_in = occ_ff + 11'd1;
                        col_we = 1'b1;
                        col_wcolor = COLOR_GRAY;
                     end else begin
                        slot_in = pos_rdata;
                     end
                     state_in = S_UP;
                  end
               end
               CMD_REMOVE: begin
                  if (occ_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     top_in = heap_rdata;
                     top_valid_in = 1'b1;
                     col_raddr = ROW_W'(heap_rdata >> 4);
                     state_in = S_RM_B;
                  end
               end
               CMD_DELETE: begin
                  if (!el_ok || color_cur != COLOR_GRAY) begin
                     status_in = ST_WRONG;
                  end else begin
                     col_we = 1'b1;
                     col_wcolor = COLOR_WHITE;
                     slot_in = pos_rdata;
                     heap_raddr = HA_W'(occ_ff);
                     state_in = S_DL1;
                  end
               end
               CMD_PEEK: begin
                  if (occ_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     top_in = heap_rdata;
                     top_valid_in = 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  clr_valid = 1'b1;
                  occ_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_RM_B: begin
            col_we = 1'b1;
            col_wel = top_ff;
            col_wcolor = COLOR_BLACK;
            if (occ_ff == 11'd1) begin
               occ_in = '0;
               state_in = S_DONE;
            end else begin
               heap_raddr = HA_W'(occ_ff);
               state_in = S_RM_L;
            end
         end
         S_RM_L: begin
            e_in = heap_rdata;
            key_raddr = EA_W'(heap_rdata);
            occ_in = occ_ff - 11'd1;
            slot_in = 11'd1;
            state_in = S_RM_K;
         end
         S_RM_K: begin
            ekey_in = key_rdata;
            state_in = S_DOWN;
         end
         S_DL1: begin
            occ_in = occ_ff - 11'd1;
            if (heap_rdata == req_ff.element) begin
               state_in = S_DONE;
            end else begin
               e_in = heap_rdata;
               key_raddr = EA_W'(req_ff.element);
               state_in = S_DL2;
            end
         end
         S_DL2: begin
            okey_in = key_rdata;
            key_raddr = EA_W'(e_ff);
            state_in = S_DL3;
         end
         S_DL3: begin
            // The deleted element's keys against those of the entry moved in.
            cmp_a = okey_ff;
            cmp_b = key_rdata;
            ekey_in = key_rdata;
            state_in = ahead ? S_DOWN : S_UP;
         end
         S_UP: begin
            if (slot_ff <= 11'd1) begin
               state_in = S_FIN;
            end else begin
               heap_raddr = HA_W'(slot_ff >> 1);
               state_in = S_UP1;
            end
         end
         S_UP1: begin
            oel_in = heap_rdata;
            key_raddr = EA_W'(heap_rdata);
            state_in = S_UP2;
         end
         S_UP2: begin
            cmp_a = ekey_ff;
            cmp_b = key_rdata;
            if (ahead) begin
               heap_we = 1'b1;
               heap_waddr = HA_W'(slot_ff);
               heap_wdata = oel_ff;
               pos_we = 1'b1;
               pos_waddr = EA_W'(oel_ff);
               pos_wdata = slot_ff;
               slot_in = slot_ff >> 1;
               state_in = S_UP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DOWN: begin
            if (left > {1'b0, occ_ff}) begin
               state_in = S_FIN;
            end else begin
               heap_raddr = HA_W'(left);
               state_in = S_D1;
            end
         end
         S_D1: begin
            oel_in = heap_rdata;
            key_raddr = EA_W'(heap_rdata);
            pick_in = left[10:0];
            heap_raddr = HA_W'(right);
            state_in = S_D2;
         end
         S_D2: begin
            okey_in = key_rdata;
            if (right <= {1'b0, occ_ff}) begin
               rel_in = heap_rdata;
               key_raddr = EA_W'(heap_rdata);
               state_in = S_D3;
            end else begin
               state_in = S_D4;
            end
         end
         S_D3: begin
            cmp_a = key_rdata;
            cmp_b = okey_ff;
            if (ahead) begin
               okey_in = key_rdata;
               oel_in = rel_ff;
               pick_in = right[10:0];
            end
            state_in = S_D4;
         end
         S_D4: begin
            cmp_a = okey_ff;
            cmp_b = ekey_ff;
            if (ahead) begin
               heap_we = 1'b1;
               heap_waddr = HA_W'(slot_ff);
               heap_wdata = oel_ff;
               pos_we = 1'b1;
               pos_waddr = EA_W'(oel_ff);
               pos_wdata = slot_ff;
               slot_in = pick_ff;
               state_in = S_DOWN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            heap_we = 1'b1;
            heap_waddr = HA_W'(slot_ff);
            heap_wdata = e_ff;
            pos_we = 1'b1;
            pos_waddr = EA_W'(e_ff);
            pos_wdata = slot_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_payload.status = status_ff;
      rsp_payload.top_element = top_ff;
      rsp_payload.top_valid = top_valid_ff;
      rsp_payload.is_empty = (occ_ff == '0);
      rsp_payload.is_full = ({6'b0, occ_ff} == CAP_L);
      rsp_payload.count = occ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff <= '0;
         largest_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) begin
            row_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         if (csr_wr_en) begin
            largest_ff <= csr_wdata;
         end
         if (clr_valid) begin
            for (int i = 0; i < ROWS; i++) begin
               row_valid_ff[i] <= 1'b0;
            end
         end else if (col_we) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      slot_ff <= slot_in;
      pick_ff <= pick_in;
      e_ff <= e_in;
      oel_ff <= oel_in;
      rel_ff <= rel_in;
      ekey_ff <= ekey_in;
      okey_ff <= okey_in;
      top_ff <= top_in;
      top_valid_ff <= top_valid_in;
      status_ff <= status_in;
   end
endmodule

[verif/indexed_lex_priority_heap_tb.sv]
// ----------------------------------------------------------------------------
// indexed_lex_priority_heap_tb
// Self-checking bench for the indexed lexicographic priority heap. Commands
// are driven in bursts with random gaps. A heap model in the scoreboard
// predicts every result, and each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module indexed_lex_priority_heap_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lph_pkg::*;

   localparam int CAP = 1024;
   localparam int WATCHDOG_LIMIT = 20000;

   int mismatches = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   class heap_scoreboard;
      logic [9:0]  slots[CAP+1];
      logic [10:0] slot_of[CAP];
      color_type   colour[CAP];
      key_set_type keys[CAP];
      int          occupied;
      bit          largest;
      rsp_type     pending[$];

      function new();
         occupied = 0;
         largest  = 0;
         foreach (colour[i]) colour[i] = COLOR_WHITE;
      endfunction

      // Lexicographic order on the four signed keys.
      function bit ranks_ahead(int a, int b);
         int c;
         c = 0;
         if (keys[a].key_first != keys[b].key_first)
            c = (keys[a].key_first < keys[b].key_first) ? -1 : 1;
         else if (keys[a].key_second != keys[b].key_second)
            c = (keys[a].key_second < keys[b].key_second) ? -1 : 1;
         else if (keys[a].key_third != keys[b].key_third)
            c = (keys[a].key_third < keys[b].key_third) ? -1 : 1;
         else if (keys[a].key_fourth != keys[b].key_fourth)
            c = (keys[a].key_fourth < keys[b].key_fourth) ? -1 : 1;
         return largest ? (c > 0) : (c < 0);
      endfunction

      function void sift_up(int s);
         int e;
         int p;
         e = slots[s];
         while (s > 1) begin
            p = s >> 1;
            if (!ranks_ahead(e, slots[p])) break;
            slots[s] = slots[p];
            slot_of[slots[p]] = 11'(s);
            s = p;
         end
         slots[s] = 10'(e);
         slot_of[e] = 11'(s);
      endfunction

      function void sift_down(int s);
         int e;
         int pick;
         e = slots[s];
         forever begin
            if (2 * s > occupied) break;
            pick = 2 * s;
            if (pick + 1 <= occupied && ranks_ahead(slots[pick+1], slots[pick]))
               pick++;
            if (!ranks_ahead(slots[pick], e)) break;
            slots[s] = slots[pick];
            slot_of[slots[pick]] = 11'(s);
            s = pick;
         end
         slots[s] = 10'(e);
         slot_of[e] = 11'(s);
      endfunction

      function void note_command(req_type r);
         rsp_type o;
         int el;
         int last;
         int s;
         o = '0;
         el = r.element;
         case (r.cmd)
            CMD_UPDATE: begin
               if (colour[el] == COLOR_BLACK) o.status = ST_WRONG;
               else if (colour[el] == COLOR_WHITE && occupied >= CAP) o.status = ST_FULL;
               else begin
                  keys[el] = {r.key_first, r.key_second, r.key_third, r.key_fourth};
                  if (colour[el] == COLOR_WHITE) begin
                     occupied++;
                     slots[occupied] = 10'(el);
                     slot_of[el] = 11'(occupied);
                     colour[el] = COLOR_GRAY;
                     sift_up(occupied);
                  end else begin
                     sift_up(slot_of[el]);
                  end
               end
            end
            CMD_REMOVE: begin
               if (occupied == 0) o.status = ST_EMPTY;
               else begin
                  o.top_element = slots[1];
                  o.top_valid = 1;
                  colour[slots[1]] = COLOR_BLACK;
                  if (occupied == 1) occupied = 0;
                  else begin
                     slots[1] = slots[occupied];
                     slot_of[slots[1]] = 11'd1;
                     occupied--;
                     sift_down(1);
                  end
               end
            end
            CMD_DELETE: begin
               if (colour[el] != COLOR_GRAY) o.status = ST_WRONG;
               else begin
                  last = slots[occupied];
                  colour[el] = COLOR_WHITE;
                  if (last == el) occupied--;
                  else begin
                     s = slot_of[el];
                     slots[s] = 10'(last);
                     slot_of[last] = 11'(s);
                     occupied--;
                     if (ranks_ahead(el, last)) sift_down(s);
                     else sift_up(s);
                  end
               end
            end
            CMD_PEEK: begin
               if (occupied == 0) o.status = ST_EMPTY;
               else begin
                  o.top_element = slots[1];
                  o.top_valid = 1;
               end
            end
            CMD_CLEAR: begin
               foreach (colour[i]) colour[i] = COLOR_WHITE;
               occupied = 0;
            end
            default: ;
         endcase
         o.is_empty = (occupied == 0);
         o.is_full = (occupied == CAP);
         o.count = occupied[10:0];
         pending.push_back(o);
      endfunction

      task check_result(rsp_type got);
         rsp_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result, waiting", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (got.status !== w.status) report_mismatch("status", got.status, w.status);
         if (got.top_element !== w.top_element)
            report_mismatch("top_element", got.top_element, w.top_element);
         if (got.top_valid !== w.top_valid)
            report_mismatch("top_valid", got.top_valid, w.top_valid);
         if (got.is_empty !== w.is_empty) report_mismatch("is_empty", got.is_empty, w.is_empty);
         if (got.is_full !== w.is_full) report_mismatch("is_full", got.is_full, w.is_full);
         if (got.count !== w.count) report_mismatch("count", got.count, w.count);
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   logic    csr_wr_en = 0;
   logic    csr_wdata = 0;

   heap_scoreboard board = new();
   int idle_cycles = 0;
   int results_seen = 0;
   int commands_sent = 0;
   int gap_left = 0;

   always #4 clock = ~clock;

   indexed_lex_priority_heap #(.CAPACITY(CAP)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            board.check_result(rsp_payload);
            results_seen++;
         end
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("** indexed_lex_priority_heap: FAILED **");
            $finish;
         end
      end
   end

   // Hands one item over and waits until busy drops again. Within a burst start
   // stays high, so the next item is offered as soon as the block is free;
   // start drops only for a gap between bursts and while results are drained.
   task automatic send_command(input req_type r);
      if (gap_left > 0) begin
         start <= 0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         gap_left = $urandom_range(1, 40);
      end
      start <= 1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(r);
      commands_sent++;
   endtask

   task automatic drain_results();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_order(input bit largest);
      csr_wr_en <= 1;
      csr_wdata <= largest;
      @(posedge clock);
      board.largest = largest;
      csr_wr_en <= 0;
      csr_wdata <= 0;
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 3);
         3: return -$urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type make_command(input int cmd, input int el);
      req_type r;
      r.cmd = 3'(cmd);
      r.element = 10'(el);
      r.key_first = pick_key();
      r.key_second = pick_key();
      r.key_third = pick_key();
      r.key_fourth = pick_key();
      return r;
   endfunction

   task automatic random_phase(input int n, input int pool);
      int c;
      int w;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(0, 99);
         if (w < 45) c = CMD_UPDATE;
         else if (w < 70) c = CMD_REMOVE;
         else if (w < 85) c = CMD_DELETE;
         else if (w < 95) c = CMD_PEEK;
         else if (w < 97) c = CMD_CLEAR;
         else c = $urandom_range(5, 7);
         send_command(make_command(c, $urandom_range(0, pool - 1)));
      end
   endtask

   initial begin
      req_type r;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty heap, extremes of keys, bad-state cases, odd commands.
      send_command(make_command(CMD_REMOVE, 0));
      send_command(make_command(CMD_PEEK, 0));
      send_command(make_command(CMD_DELETE, 1023));
      r = make_command(CMD_UPDATE, 1023);
      r.key_first = 32'h8000_0000; r.key_second = 32'h8000_0000;
      r.key_third = 32'h8000_0000; r.key_fourth = 32'h8000_0000;
      send_command(r);
      r.element = 0; r.key_fourth = 32'h7fff_ffff;
      send_command(r);
      r.element = 5;
      send_command(r);
      r.element = 682; r.key_first = 32'h7fff_ffff;
      send_command(r);
      send_command(make_command(CMD_PEEK, 0));
      send_command(make_command(CMD_REMOVE, 0));
      send_command(make_command(CMD_UPDATE, 1023));
      send_command(make_command(CMD_DELETE, 1023));
      send_command(make_command(CMD_DELETE, 682));
      send_command(make_command(CMD_DELETE, 5));
      send_command(make_command(5, 341));
      send_command(make_command(7, 341));
      send_command(make_command(CMD_CLEAR, 0));
      send_command(make_command(CMD_UPDATE, 1023));
      drain_results();

      write_order(1);
      random_phase(250, 24);
      drain_results();
      write_order(0);
      random_phase(250, 64);
      drain_results();
      write_order(1);
      random_phase(250, 1024);
      drain_results();
      write_order(0);
      random_phase(250, 8);
      drain_results();

      $display("covered %0d commands and %0d results over both pop orders",
               commands_sent, results_seen);
      if (mismatches == 0) $display("** indexed_lex_priority_heap: PASSED **");
      else $display("** indexed_lex_priority_heap: FAILED **");
      $finish;
   end
endmodule
